// File: rtl/core/ute_pkg.sv
// Shared types, constants and helper functions of the UTF-8 terminal escaper.
package ute_pkg;

  localparam int JobUnits   = 4;
  localparam int QueueDepth = 4;

  localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CHAR_X         = 8'h78;
  localparam logic [7:0]  CHAR_DEL       = 8'h7F;
  localparam logic [7:0]  LEAD_MIN       = 8'hC2;
  localparam logic [7:0]  LEAD_MAX       = 8'hF4;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;

  // One unit of output work: a byte copied as is, or written as a hex escape.
  typedef struct packed {
    logic       esc;
    logic [7:0] value;
  } unit_t;

  // Everything one accepted byte causes.
  typedef struct packed {
    unit_t [JobUnits-1:0] units;
    logic  [2:0]          unit_count;
  } job_t;

  // Occupancy status of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] digit;
    if (nibble < 4'd10) begin
      digit = 8'h30 + {4'd0, nibble};
    end else begin
      digit = 8'h37 + {4'd0, nibble};
    end
    return digit;
  endfunction

  function automatic logic unsafe_format(input logic [20:0] cp);
    return (cp == 21'h00061C)
        || (cp >= 21'h00200B && cp <= 21'h00200F)
        || (cp >= 21'h00202A && cp <= 21'h00202E)
        || (cp >= 21'h002060 && cp <= 21'h00206F)
        || (cp == 21'h00FEFF);
  endfunction

endpackage

// File: rtl/core/ute_in_if.sv
// Input channel: one raw text byte with its end-of-text flag per transfer.
interface ute_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: rtl/core/ute_out_if.sv
// Output channel: one escaped text byte with its end-of-run flag per transfer.
interface ute_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/core/ute_front.sv
// Front end: accepts bytes, tracks pending UTF-8 sequences and builds output jobs.
module ute_front (
  input  logic                     clk,
  input  logic                     rst,
  ute_in_if.sink                   in_ch,
  input  ute_pkg::queue_status_t   q_status,
  output logic                     push,
  output ute_pkg::job_t            push_job
);
  import ute_pkg::*;

  logic [7:0]  held [3];
  logic [1:0]  held_count;
  logic [2:0]  seq_len;
  logic [20:0] cp;

  logic [1:0]  held_count_next;
  logic [2:0]  seq_len_next;
  logic [20:0] cp_next;
  logic        store_held;
  logic [1:0]  store_idx;

  logic [7:0]  b;
  logic        eot;
  logic        fresh;
  logic        complete;
  logic        bad_value;
  logic [20:0] cp_ext;
  logic [20:0] cp_min;
  logic [2:0]  n;
  job_t        job;
  logic        accept;

  assign b      = in_ch.in_byte;
  assign eot    = in_ch.end_of_text;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_status.full;

  assign cp_ext   = {cp[14:0], b[5:0]};
  assign complete = ({1'b0, held_count} + 3'd1) >= seq_len;
  assign cp_min   = (seq_len == 3'd2) ? 21'h000080 :
                    (seq_len == 3'd3) ? 21'h000800 : 21'h010000;
  assign bad_value = (cp_ext < cp_min) || (cp_ext > CP_MAX)
                  || (cp_ext >= SURR_LO && cp_ext <= SURR_HI);

  always_comb begin
    n               = 3'd0;
    job             = '0;
    fresh           = 1'b0;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    cp_next         = cp;
    store_held      = 1'b0;
    store_idx       = held_count;

    if (held_count == 2'd0) begin
      fresh = 1'b1;
    end else if (b[7:6] != 2'b10) begin
      // Broken sequence: every held byte is escaped, then the byte starts over.
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_count)) begin
          job.units[n[1:0]] = '{esc: 1'b1, value: held[k]};
          n = n + 3'd1;
        end
      end
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      cp_next         = '0;
      fresh           = 1'b1;
    end else if (complete || eot) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_count)) begin
          job.units[n[1:0]] = '{esc: !complete || bad_value || (cp_ext >= 21'h80 &&
                                cp_ext <= 21'h9F) || unsafe_format(cp_ext),
                                value: held[k]};
          n = n + 3'd1;
        end
      end
      job.units[n[1:0]] = '{esc: !complete || bad_value || (cp_ext >= 21'h80 &&
                            cp_ext <= 21'h9F) || unsafe_format(cp_ext), value: b};
      n = n + 3'd1;
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      cp_next         = '0;
    end else begin
      store_held      = 1'b1;
      held_count_next = held_count + 2'd1;
      cp_next         = cp_ext;
    end

    if (fresh) begin
      if (b < 8'h20 || b == CHAR_DEL) begin
        job.units[n[1:0]] = '{esc: 1'b1, value: b};
        n = n + 3'd1;
      end else if (b < 8'h80) begin
        job.units[n[1:0]] = '{esc: 1'b0, value: b};
        n = n + 3'd1;
      end else if (b >= LEAD_MIN && b <= LEAD_MAX && !eot) begin
        store_held      = 1'b1;
        store_idx       = 2'd0;
        held_count_next = 2'd1;
        if (b <= 8'hDF) begin
          seq_len_next = 3'd2;
          cp_next      = {16'd0, b[4:0]};
        end else if (b <= 8'hEF) begin
          seq_len_next = 3'd3;
          cp_next      = {17'd0, b[3:0]};
        end else begin
          seq_len_next = 3'd4;
          cp_next      = {18'd0, b[2:0]};
        end
      end else begin
        // Invalid lead byte, or a lead byte that ends the text.
        job.units[n[1:0]] = '{esc: 1'b1, value: b};
        n = n + 3'd1;
      end
    end
    job.unit_count = n;
  end

  assign push     = accept && (n != 3'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= 3'd0;
      cp         <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
      seq_len    <= seq_len_next;
      cp         <= cp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_held) begin
      held[store_idx] <= b;
    end
  end

  a_held_below_len: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) |-> ({1'b0, held_count} < seq_len))
    else $error("held byte count not below sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (held_count == 2'd0) |-> (seq_len == 3'd0 && cp == 21'd0))
    else $error("pending state left over with no held bytes");

endmodule

// File: rtl/core/ute_queue.sv
// Job queue between the front end and the output sequencer.
module ute_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ute_pkg::job_t          push_job,
  input  logic                   pop,
  output ute_pkg::job_t          head_job,
  output ute_pkg::queue_status_t status
);
  import ute_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;

  assign status.full  = (fill == (PtrW+1)'(QueueDepth));
  assign status.empty = (fill == '0);
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

// File: rtl/core/ute_back.sv
// Output sequencer: walks the head job and sends its bytes through an output register.
module ute_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ute_pkg::job_t          head_job,
  input  ute_pkg::queue_status_t q_status,
  output logic                   pop,
  ute_out_if.source              out_ch
);
  import ute_pkg::*;

  logic [1:0] unit_idx;
  logic [1:0] sub_idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  unit_t      cur;
  logic       load;
  logic       unit_done;
  logic       job_done;
  logic [7:0] byte_next;

  assign cur       = head_job.units[unit_idx];
  assign load      = !q_status.empty && (!out_valid || out_ch.ready);
  assign unit_done = !cur.esc || (sub_idx == 2'd3);
  assign job_done  = unit_done && ({1'b0, unit_idx} + 3'd1 == head_job.unit_count);
  assign pop       = load && job_done;

  always_comb begin
    if (!cur.esc) begin
      byte_next = cur.value;
    end else begin
      case (sub_idx)
        2'd0:    byte_next = CHAR_BACKSLASH;
        2'd1:    byte_next = CHAR_X;
        2'd2:    byte_next = hex_digit(cur.value[7:4]);
        default: byte_next = hex_digit(cur.value[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      unit_idx  <= 2'd0;
      sub_idx   <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (job_done) begin
          unit_idx <= 2'd0;
          sub_idx  <= 2'd0;
        end else if (unit_done) begin
          unit_idx <= unit_idx + 2'd1;
          sub_idx  <= 2'd0;
        end else begin
          sub_idx <= sub_idx + 2'd1;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      out_last <= job_done;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;

  a_mid_escape: assert property (@(posedge clk) disable iff (rst)
    (sub_idx != 2'd0) |-> (!q_status.empty && cur.esc))
    else $error("escape in progress without an escaped head unit");

  a_unit_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty |-> ({1'b0, unit_idx} < head_job.unit_count))
    else $error("unit index beyond head job");

endmodule

// File: rtl/core/utf8_terminal_escaper_top.sv
// Top level of the UTF-8 terminal escaper.
//
// The input channel carries one raw text byte per transfer, with end_of_text set
// on the last byte of a string. The output channel carries the escaped text, one
// byte per transfer, with last_of_run set on the final byte caused by an input.
// An input that only extends a pending UTF-8 sequence causes no output at all.
// The front end accepts one byte per cycle, classifies it against the pending
// sequence and pushes a job of one to four units into a four-entry queue. The
// back end turns each unit into one copied byte or four escape bytes.
// The first output byte of an item passes through the queue slot and then the
// output register before it can transfer on the output channel.
// Throughput is one input byte per cycle while the queue has room, and one
// output byte per cycle while the receiver is ready; an escaped unit occupies
// the output for four bytes. The queue decouples the sides: the front keeps
// taking bytes while a result waits, and only stops when the queue is full.
// A stalled receiver holds the output byte and fills the queue until input
// ready drops. Synchronous reset empties the queue, drops output valid and
// clears any pending sequence.
module utf8_terminal_escaper_top (
  input  logic      clk,
  input  logic      rst,
  ute_in_if.sink    in_ch,
  ute_out_if.source out_ch
);
  import ute_pkg::*;

  // Push side of the job queue.
  logic          push;
  job_t          push_job;
  // Pop side of the job queue.
  logic          pop;
  job_t          head_job;
  queue_status_t q_status;

  // Front end: validation and classification of the incoming bytes.
  ute_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Queue that lets the front and the back stall independently.
  ute_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Back end: expands each job into output byte transfers.
  ute_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the UTF-8 terminal escaper: directed and random text streams.
`timescale 1ns / 1ps

module testbench;
  import ute_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 5;
  // The longest correct stretch without any transfer is the deliberate output hold below,
  // plus a few random idle cycles. This limit is many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int OUTPUT_HOLD_CYCLES = 80;
  // First output byte comes through the queue and the output register. Allow a generous tail
  // so that a stray extra byte from the block is still caught.
  localparam int TAIL_CYCLES = 20;

  // One byte of expected escaped text.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // Scoreboard: predicts the escaped text for every accepted input byte and checks every
  // output byte against the oldest prediction.
  class escape_scoreboard;
    text_beat_t  expected_text[$];
    logic [7:0]  pend_bytes[3];
    logic [1:0]  pend_count;
    logic [2:0]  pend_len;
    logic [20:0] pend_cp;
    int unsigned fail_count;
    int unsigned escape_units;
    int unsigned copied_seqs;

    function new();
      pend_bytes = '{default: 8'h00};
      clear_pending();
      fail_count = 0;
      escape_units = 0;
      copied_seqs = 0;
    endfunction

    function void clear_pending();
      pend_count = 2'd0;
      pend_len = 3'd0;
      pend_cp = 21'd0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) begin
        return 8'h30 + {4'd0, nib};
      end
      return 8'h41 + {4'd0, nib} - 8'd10;
    endfunction

    // Bidi controls and invisible format characters that must never reach a terminal raw.
    function logic is_hidden_format(logic [20:0] cp);
      return (cp == 21'h00061C) || (cp == 21'h00FEFF)
          || (cp >= 21'h00200B && cp <= 21'h00200F)
          || (cp >= 21'h00202A && cp <= 21'h00202E)
          || (cp >= 21'h002060 && cp <= 21'h00206F);
    endfunction

    function void push_byte(logic [7:0] b);
      text_beat_t beat;
      beat.data = b;
      beat.last = 1'b0;
      expected_text.push_back(beat);
    endfunction

    function void push_escaped(logic [7:0] b);
      push_byte(CHAR_BACKSLASH);
      push_byte(CHAR_X);
      push_byte(hex_char(b[7:4]));
      push_byte(hex_char(b[3:0]));
      escape_units++;
    endfunction

    function void escape_pending();
      for (int k = 0; k < pend_count; k++) begin
        push_escaped(pend_bytes[k]);
      end
    endfunction

    // A byte seen with no sequence in progress.
    function void start_fresh(logic [7:0] b, logic eot);
      if (b < 8'h20 || b == CHAR_DEL) begin
        push_escaped(b);
        return;
      end
      if (b < 8'h80) begin
        push_byte(b);
        return;
      end
      if (b >= LEAD_MIN && b <= 8'hDF) begin
        pend_len = 3'd2;
        pend_cp = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        pend_len = 3'd3;
        pend_cp = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= LEAD_MAX) begin
        pend_len = 3'd4;
        pend_cp = {18'd0, b[2:0]};
      end else begin
        push_escaped(b);
        return;
      end
      if (eot) begin
        // A lead byte that ends the string is a truncated sequence.
        push_escaped(b);
        clear_pending();
      end else begin
        pend_bytes[0] = b;
        pend_count = 2'd1;
      end
    endfunction

    // Note an accepted input transfer and queue up everything it causes.
    function void note_byte(logic [7:0] b, logic eot);
      int          first_new;
      logic [20:0] cp;
      logic [20:0] lowest;
      logic        well_formed;
      first_new = expected_text.size();
      if (pend_count == 2'd0) begin
        start_fresh(b, eot);
      end else if (b[7:6] != 2'b10) begin
        // Broken sequence: held bytes are escaped and the new byte starts over.
        escape_pending();
        clear_pending();
        start_fresh(b, eot);
      end else begin
        cp = {pend_cp[14:0], b[5:0]};
        pend_cp = cp;
        if ({1'b0, pend_count} + 3'd1 >= pend_len) begin
          lowest = (pend_len == 3'd2) ? 21'h80 : (pend_len == 3'd3) ? 21'h800 : 21'h10000;
          well_formed = cp >= lowest && cp <= CP_MAX && !(cp >= SURR_LO && cp <= SURR_HI);
          if (!well_formed || (cp >= 21'h80 && cp <= 21'h9F) || is_hidden_format(cp)) begin
            escape_pending();
            push_escaped(b);
          end else begin
            for (int k = 0; k < pend_count; k++) begin
              push_byte(pend_bytes[k]);
            end
            push_byte(b);
            copied_seqs++;
          end
          clear_pending();
        end else if (eot) begin
          escape_pending();
          push_escaped(b);
          clear_pending();
        end else begin
          pend_bytes[pend_count] = b;
          pend_count = pend_count + 2'd1;
        end
      end
      if (expected_text.size() > first_new) begin
        expected_text[expected_text.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      // Keep the log readable when the block is badly broken; every failure still counts.
      if (fail_count < 40) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      fail_count++;
    endtask

    // Check an accepted output transfer against the oldest expected byte.
    task check_byte(logic [7:0] data, logic last);
      text_beat_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("output byte %02h (last %0b) with nothing expected", data, last));
        return;
      end
      want = expected_text.pop_front();
      if (data !== want.data) begin
        report($sformatf("out_byte %02h, expected %02h", data, want.data));
      end
      if (last !== want.last) begin
        report($sformatf("last_of_run %0b on byte %02h, expected %0b", last, data, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ute_in_if  in_ch();
  ute_out_if out_ch();

  utf8_terminal_escaper_top dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  escape_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int          hold_left;
  int unsigned sent_count;
  int unsigned in_xfers;
  int unsigned out_xfers;
  int          quiet_cycles;
  logic [8:0]  chunk[$];  // bit 8 is end_of_text, bits 7:0 the byte

  // Directed text: controls and DEL, stray and invalid lead bytes, a C1 control, a copied
  // two-byte character, an overlong form, a surrogate, a zero-width space, a code point above
  // the Unicode limit, a sequence broken by ASCII, and two truncations by end of text.
  logic [8:0] directed_bytes[$] = '{
    9'h000, 9'h07F, 9'h01F, 9'h17E, 9'h080, 9'h0C1, 9'h0FF,
    9'h0C2, 9'h080,
    9'h0C3, 9'h0A9,
    9'h0E0, 9'h080, 9'h080,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0E2, 9'h080, 9'h08B,
    9'h0F4, 9'h090, 9'h080, 9'h080,
    9'h0C3, 9'h041,
    9'h0E2, 9'h182,
    9'h1F0
  };

  // Monitor: every transfer at a rising edge goes to the scoreboard. The input side is noted
  // before the output side is checked, although results always trail their input anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_byte(in_ch.in_byte, in_ch.end_of_text);
        in_xfers++;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_byte(out_ch.out_byte, out_ch.last_of_run);
        out_xfers++;
      end
    end
  end

  // Watchdog: counts consecutive cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: decides ready for the next cycle at every edge. A hold request from the sender
  // side turns into a long stretch of ready low, counted here, so the block's queue fills up
  // and it has to stall its input.
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = OUTPUT_HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte and wait for its transfer. Random idle cycles come first, with valid low.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // A lead byte for a sequence of the given length. Four-byte leads may go past F4 when
  // allow_bad is set, which makes the whole group invalid.
  function automatic logic [7:0] pick_lead(int len, bit allow_bad);
    if (len == 2) begin
      return 8'($urandom_range(8'hC2, 8'hDF));
    end
    if (len == 3) begin
      return 8'($urandom_range(8'hE0, 8'hEF));
    end
    return 8'($urandom_range(8'hF0, allow_bad ? 8'hF7 : 8'hF4));
  endfunction

  function automatic logic [7:0] pick_continuation();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void push_plain(logic [7:0] b);
    chunk.push_back({1'b0, b});
  endfunction

  // Proper UTF-8 encoding of a code point at or above U+0080.
  function automatic void push_encoded(logic [20:0] cp);
    if (cp < 21'h800) begin
      push_plain({3'b110, cp[10:6]});
    end else if (cp < 21'h10000) begin
      push_plain({4'b1110, cp[15:12]});
      push_plain({2'b10, cp[11:6]});
    end else begin
      push_plain({5'b11110, cp[20:18]});
      push_plain({2'b10, cp[17:12]});
      push_plain({2'b10, cp[11:6]});
    end
    push_plain({2'b10, cp[5:0]});
  endfunction

  // Code points on and around the boundaries of every escaped class.
  function automatic logic [20:0] pick_edge_codepoint();
    case ($urandom_range(0, 17))
      0:       return 21'h80 + 21'($urandom_range(0, 31));
      1:       return 21'h061C;
      2:       return 21'h200B + 21'($urandom_range(0, 4));
      3:       return 21'h202A + 21'($urandom_range(0, 4));
      4:       return 21'h2060 + 21'($urandom_range(0, 15));
      5:       return 21'hFEFF;
      6:       return 21'hD800 + 21'($urandom_range(0, 12'h7FF));
      7:       return 21'hA0;
      8:       return 21'h061B + 21'(2 * $urandom_range(0, 1));
      9:       return 21'h200A;
      10:      return 21'h2010 + 21'(25 * $urandom_range(0, 1));
      11:      return 21'h202F + 21'(48 * $urandom_range(0, 1));
      12:      return 21'h205F;
      13:      return 21'hFEFE + 21'(2 * $urandom_range(0, 1));
      14:      return 21'h7FF + 21'($urandom_range(0, 1));
      15:      return 21'hFFFF + 21'($urandom_range(0, 1));
      16:      return 21'hD7FF + 21'(12'h801 * $urandom_range(0, 1));
      default: return CP_MAX;
    endcase
  endfunction

  // Build one group of random text: ASCII, whole sequences with random content or edge
  // code points, broken or truncated sequences, or plain noise.
  task automatic build_chunk();
    int         len;
    int         held;
    logic [7:0] b;
    chunk.delete();
    len = $urandom_range(2, 4);
    case ($urandom_range(0, 9))
      0, 1: begin
        push_plain(8'($urandom_range(0, 127)));
      end
      2, 3, 4: begin
        // Random continuation content hits overlong forms, surrogates and the upper limit.
        push_plain(pick_lead(len, 1'b1));
        repeat (len - 1) push_plain(pick_continuation());
      end
      5: begin
        push_encoded(pick_edge_codepoint());
      end
      6: begin
        push_plain(pick_lead(len, 1'b0));
        held = $urandom_range(0, len - 2);
        repeat (held) push_plain(pick_continuation());
        b = 8'($urandom_range(0, 191));
        if (b >= 8'h80) begin
          b = b + 8'h40;
        end
        push_plain(b);
      end
      7: begin
        push_plain(pick_lead(len, 1'b0));
        held = $urandom_range(0, len - 2);
        repeat (held) push_plain(pick_continuation());
        chunk[chunk.size() - 1][8] = 1'b1;
      end
      8: begin
        repeat ($urandom_range(1, 3)) push_plain(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(2, 6)) push_plain(8'($urandom_range(8'h20, 8'h7E)));
      end
    endcase
    if ($urandom_range(0, 99) < 10) begin
      chunk[chunk.size() - 1][8] = 1'b1;
    end
  endtask

  task automatic run_random(input int unsigned target);
    while (sent_count < target) begin
      build_chunk();
      foreach (chunk[i]) begin
        send_byte(chunk[i][7:0], chunk[i][8]);
      end
    end
  endtask

  // Stop offering and wait until every predicted byte has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    hold_request = 1'b0;
    sent_count = 0;
    in_xfers = 0;
    out_xfers = 0;
    // Phase one: the sender idles less than the receiver.
    send_idle_pct = 38;
    recv_idle_pct = 45;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    end
    run_random(140);
    drain();

    // Phase two: the roles swap.
    send_idle_pct = 45;
    recv_idle_pct = 38;
    run_random(255);
    drain();

    // Phase three: full rate on both sides, opened by a long output hold while the sender
    // keeps offering bytes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(370);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input and %0d output transfers: %0d escaped bytes, %0d copied",
             in_xfers, out_xfers, sb.escape_units, sb.copied_seqs);
    $display("multi-byte characters, three idle mixes and one long output stall.");
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
